/* src/assert_macros.svh */
// Assertion macros shared by the trilinear interpolator RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TFIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TFIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TFIG_ASSERT(lbl, prop, msg)
`define TFIG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/tfig_pkg.sv */
// Package for the trilinear field interpolator: config, command and status types.
// No dependencies.
`timescale 1ns / 1ps

package tfig_pkg;

  localparam int DefMaxPointsX   = 16;
  localparam int DefMaxPointsY   = 16;
  localparam int DefMaxPointsZ   = 64;
  localparam int DefNumComponents = 6;

  localparam int InDataW  = 152;
  localparam int OutDataW = 176;
  localparam int GradW    = 48;

  typedef enum logic [2:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_Y_ORIGIN   = 3'd1,
    REG_INV_STEP_X = 3'd2,
    REG_INV_STEP_Y = 3'd3,
    REG_INV_STEP_Z = 3'd4,
    REG_POINTS_X   = 3'd5,
    REG_POINTS_Y   = 3'd6,
    REG_POINTS_Z   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [31:0]        inv_step_x;
    logic [31:0]        inv_step_y;
    logic [31:0]        inv_step_z;
    logic [4:0]         points_x;
    logic [4:0]         points_y;
    logic [6:0]         points_z;
  } cfg_t;

  typedef struct packed {
    logic       load_item;
    logic       wr_en;
    logic       mul_map;
    logic       loc;
    logic       adr0;
    logic       adr1;
    logic       rd_en;
    logic       cap_en;
    logic       lerp_en;
    logic       mul_scale;
    logic       sfin;
    logic       out_load;
    logic [3:0] sel;
    logic [2:0] cap_idx;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic comp_ok;
    logic out_free;
  } status_t;

endpackage

/* src/tfig_regs.sv */
// APB configuration registers of the trilinear field interpolator.
// Depends on tfig_pkg.
`timescale 1ns / 1ps

module tfig_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tfig_pkg::cfg_t      cfg_o
);

  tfig_pkg::cfg_t     cfg_q;
  tfig_pkg::reg_idx_e idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = tfig_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin   <= '0;
      cfg_q.y_origin   <= '0;
      cfg_q.inv_step_x <= 32'd65536;
      cfg_q.inv_step_y <= 32'd65536;
      cfg_q.inv_step_z <= 32'd65536;
      cfg_q.points_x   <= 5'd16;
      cfg_q.points_y   <= 5'd16;
      cfg_q.points_z   <= 7'd64;
    end else if (wr) begin
      unique case (idx)
        tfig_pkg::REG_X_ORIGIN:   cfg_q.x_origin   <= pwdata;
        tfig_pkg::REG_Y_ORIGIN:   cfg_q.y_origin   <= pwdata;
        tfig_pkg::REG_INV_STEP_X: cfg_q.inv_step_x <= pwdata;
        tfig_pkg::REG_INV_STEP_Y: cfg_q.inv_step_y <= pwdata;
        tfig_pkg::REG_INV_STEP_Z: cfg_q.inv_step_z <= pwdata;
        tfig_pkg::REG_POINTS_X:   cfg_q.points_x   <= pwdata[4:0];
        tfig_pkg::REG_POINTS_Y:   cfg_q.points_y   <= pwdata[4:0];
        tfig_pkg::REG_POINTS_Z:   cfg_q.points_z   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tfig_pkg::REG_X_ORIGIN:   prdata = cfg_q.x_origin;
      tfig_pkg::REG_Y_ORIGIN:   prdata = cfg_q.y_origin;
      tfig_pkg::REG_INV_STEP_X: prdata = cfg_q.inv_step_x;
      tfig_pkg::REG_INV_STEP_Y: prdata = cfg_q.inv_step_y;
      tfig_pkg::REG_INV_STEP_Z: prdata = cfg_q.inv_step_z;
      tfig_pkg::REG_POINTS_X:   prdata = {27'd0, cfg_q.points_x};
      tfig_pkg::REG_POINTS_Y:   prdata = {27'd0, cfg_q.points_y};
      tfig_pkg::REG_POINTS_Z:   prdata = {25'd0, cfg_q.points_z};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* src/tfig_ctrl.sv */
// Sequencer of the trilinear field interpolator: issues datapath commands per request.
// Depends on tfig_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfig_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tfig_pkg::status_t status_i,
  output tfig_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_MMUL = 4'd2;
  localparam logic [3:0] S_MLOC = 4'd3;
  localparam logic [3:0] S_ADR0 = 4'd4;
  localparam logic [3:0] S_ADR1 = 4'd5;
  localparam logic [3:0] S_READ = 4'd6;
  localparam logic [3:0] S_LERP = 4'd7;
  localparam logic [3:0] S_SMUL = 4'd8;
  localparam logic [3:0] S_SFIN = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.sel  = cnt_q[3:0];
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DEC;
        end
      end
      S_DEC: begin
        cnt_d = '0;
        if (!status_i.is_query) begin
          cmd_o.wr_en = 1'b1;
          state_d     = S_IDLE;
        end else if (!status_i.comp_ok) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MMUL;
        end
      end
      S_MMUL: begin
        cmd_o.mul_map = 1'b1;
        state_d       = S_MLOC;
      end
      S_MLOC: begin
        cmd_o.loc = 1'b1;
        if (cnt_q == 5'd2) begin
          cnt_d   = '0;
          state_d = S_ADR0;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_MMUL;
        end
      end
      S_ADR0: begin
        cmd_o.adr0 = 1'b1;
        state_d    = S_ADR1;
      end
      S_ADR1: begin
        cmd_o.adr1 = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en   = (cnt_q != 5'd8);
        cmd_o.cap_en  = (cnt_q != 5'd0);
        cmd_o.cap_idx = 3'(cnt_q - 5'd1);
        if (cnt_q == 5'd8) begin
          cnt_d   = '0;
          state_d = S_LERP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_LERP: begin
        cmd_o.lerp_en = 1'b1;
        if (cnt_q == 5'd15) begin
          cnt_d   = '0;
          state_d = S_SMUL;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_SMUL: begin
        cmd_o.mul_scale = 1'b1;
        state_d         = S_SFIN;
      end
      S_SFIN: begin
        cmd_o.sfin = 1'b1;
        if (cnt_q == 5'd2) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_SMUL;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `TFIG_ASSERT(a_out_slot_free, cmd_o.out_load |-> status_i.out_free, "result loaded over a held one")
  `TFIG_ASSERT(a_read_cnt, (state_q == S_READ) |-> (cnt_q <= 5'd8), "corner counter overrun")
  `TFIG_ASSERT(a_load_done, (state_q == S_DEC && !status_i.is_query) |=> (state_q == S_IDLE), "load did not retire")

endmodule

/* src/tfig_dp.sv */
// Datapath of the trilinear field interpolator: field memory, shared multiplier,
// lerp unit, gradient scaling and output register. Depends on tfig_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfig_dp #(
  parameter int MAX_POINTS_X   = tfig_pkg::DefMaxPointsX,
  parameter int MAX_POINTS_Y   = tfig_pkg::DefMaxPointsY,
  parameter int MAX_POINTS_Z   = tfig_pkg::DefMaxPointsZ,
  parameter int NUM_COMPONENTS = tfig_pkg::DefNumComponents
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tfig_pkg::cfg_t                cfg_i,
  input  tfig_pkg::cmd_t                cmd_i,
  output tfig_pkg::status_t             status_o,
  input  logic [tfig_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [tfig_pkg::OutDataW-1:0] m_tdata_o,
  output logic                          m_tuser_o
);

  localparam int CompDepth = MAX_POINTS_X * MAX_POINTS_Y * MAX_POINTS_Z;
  localparam int Depth     = CompDepth * NUM_COMPONENTS;
  localparam int AW        = $clog2(Depth);
  localparam int MaxXY     = (MAX_POINTS_X > MAX_POINTS_Y) ? MAX_POINTS_X : MAX_POINTS_Y;
  localparam int MaxAll    = (MaxXY > MAX_POINTS_Z) ? MaxXY : MAX_POINTS_Z;
  localparam int NW        = $clog2(MaxAll + 1);
  localparam int IW        = $clog2(MaxAll);
  localparam logic [49:0] GradMax = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [49:0] GradMin = 50'h0_8000_0000_0000;

  function automatic logic signed [33:0] lerp(input logic signed [33:0] a,
                                              input logic signed [33:0] b,
                                              input logic [16:0] t);
    logic signed [34:0] diff;
    logic signed [53:0] prod;
    logic signed [53:0] sh;
    diff = 35'(b) - 35'(a);
    prod = 54'(diff) * 54'(signed'({1'b0, t}));
    sh   = (prod + 54'sd32768) >>> 16;
    return 34'(sh + 54'(a));
  endfunction

  function automatic logic [NW-1:0] clamp_n(input logic [6:0] raw, input int max_n);
    if (raw < 7'd2) return NW'(2);
    if (32'(raw) > 32'(max_n)) return NW'(max_n);
    return NW'(raw);
  endfunction

  // request held for the whole operation
  logic               func_q;
  logic [2:0]         comp_q;
  logic [13:0]        idx_q;
  logic [31:0]        sval_q;
  logic signed [31:0] pos_q [3];

  logic [NW-1:0] nx, ny, nz, n_sel;
  logic [AW-1:0] waddr, raddr, mem_addr;
  logic          wr_ok, we;
  logic [31:0]   mem [Depth];
  logic [31:0]   rdata_q;

  logic signed [32:0] d_sel;
  logic [31:0]        inv_sel;
  logic [33:0]        mul_a;
  logic [65:0]        prod_q;

  logic [47:0]   f_raw, lim, f_c;
  logic [31:0]   ii, nm2;
  logic          reduce;
  logic [IW-1:0] base_q [3];
  logic [16:0]   t_q [3];

  logic [AW-1:0] row_q, nxny_q, cbase_q, abase_q;

  logic signed [31:0] c_q [8];
  logic signed [33:0] ce [8];
  logic signed [33:0] lerp_q [16];
  logic signed [33:0] la, lb, g_sel;
  logic [16:0]        lt;

  logic [49:0]        r;
  logic [47:0]        grad_q [3];
  logic               sat_q;

  logic               out_valid_q;
  logic [31:0]        o_val_q;
  logic [47:0]        o_gx_q, o_gy_q, o_gz_q;
  logic               o_sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q   <= s_tuser_i;
      comp_q   <= s_tdata_i[2:0];
      idx_q    <= s_tdata_i[16:3];
      sval_q   <= s_tdata_i[48:17];
      pos_q[0] <= s_tdata_i[80:49];
      pos_q[1] <= s_tdata_i[112:81];
      pos_q[2] <= s_tdata_i[144:113];
    end
  end

  assign nx = clamp_n({2'b00, cfg_i.points_x}, MAX_POINTS_X);
  assign ny = clamp_n({2'b00, cfg_i.points_y}, MAX_POINTS_Y);
  assign nz = clamp_n(cfg_i.points_z, MAX_POINTS_Z);

  assign status_o.is_query = func_q;
  assign status_o.comp_ok  = 32'(comp_q) < 32'(NUM_COMPONENTS);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  // field memory, single port
  assign wr_ok    = status_o.comp_ok && (32'(idx_q) < 32'(CompDepth));
  assign we       = cmd_i.wr_en && wr_ok;
  assign waddr    = AW'(comp_q) * AW'(CompDepth) + AW'(idx_q);
  assign raddr    = abase_q + (cmd_i.sel[0] ? AW'(1) : '0)
                  + (cmd_i.sel[1] ? AW'(nx) : '0) + (cmd_i.sel[2] ? nxny_q : '0);
  assign mem_addr = we ? waddr : raddr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[mem_addr] <= sval_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // shared multiplier: grid mapping, then gradient scaling
  always_comb begin
    case (cmd_i.sel[1:0])
      2'd0: begin
        d_sel   = 33'(pos_q[0]) - 33'(cfg_i.x_origin);
        inv_sel = cfg_i.inv_step_x;
        n_sel   = nx;
        g_sel   = lerp_q[9];
      end
      2'd1: begin
        d_sel   = 33'(pos_q[1]) - 33'(cfg_i.y_origin);
        inv_sel = cfg_i.inv_step_y;
        n_sel   = ny;
        g_sel   = lerp_q[12];
      end
      default: begin
        d_sel   = 33'(pos_q[2]);
        inv_sel = cfg_i.inv_step_z;
        n_sel   = nz;
        g_sel   = lerp_q[15];
      end
    endcase
    if (cmd_i.mul_scale) begin
      mul_a = g_sel[33] ? 34'(-g_sel) : 34'(g_sel);
    end else if (!d_sel[32] && d_sel != '0) begin
      mul_a = {2'b00, d_sel[31:0]};
    end else begin
      mul_a = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_map || cmd_i.mul_scale) begin
      prod_q <= 66'(mul_a) * 66'(inv_sel);
    end
  end

  // clamp to the grid and split into cell base and weight
  always_comb begin
    f_raw  = prod_q[63:16];
    lim    = 48'(n_sel - NW'(1)) << 16;
    f_c    = (f_raw > lim) ? lim : f_raw;
    ii     = f_c[47:16];
    nm2    = 32'(n_sel - NW'(2));
    reduce = ii > nm2;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.loc) begin
      base_q[cmd_i.sel[1:0]] <= reduce ? IW'(nm2) : IW'(ii);
      t_q[cmd_i.sel[1:0]]    <= reduce ? 17'h10000 : {1'b0, f_c[15:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adr0) begin
      row_q   <= AW'(base_q[1]) + AW'(ny) * AW'(base_q[2]);
      nxny_q  <= AW'(nx) * AW'(ny);
      cbase_q <= AW'(comp_q) * AW'(CompDepth);
    end
    if (cmd_i.adr1) begin
      abase_q <= cbase_q + AW'(base_q[0]) + AW'(nx) * row_q;
    end
    if (cmd_i.cap_en) begin
      c_q[cmd_i.cap_idx] <= rdata_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      ce[k] = 34'(c_q[k]);
    end
  end

  // lerp schedule: value, then the three gradients
  always_comb begin
    case (cmd_i.sel)
      4'd0:  begin la = ce[0];             lb = ce[1];             lt = t_q[0]; end
      4'd1:  begin la = ce[2];             lb = ce[3];             lt = t_q[0]; end
      4'd2:  begin la = ce[4];             lb = ce[5];             lt = t_q[0]; end
      4'd3:  begin la = ce[6];             lb = ce[7];             lt = t_q[0]; end
      4'd4:  begin la = lerp_q[0];         lb = lerp_q[1];         lt = t_q[1]; end
      4'd5:  begin la = lerp_q[2];         lb = lerp_q[3];         lt = t_q[1]; end
      4'd6:  begin la = lerp_q[4];         lb = lerp_q[5];         lt = t_q[2]; end
      4'd7:  begin la = ce[1] - ce[0];     lb = ce[3] - ce[2];     lt = t_q[1]; end
      4'd8:  begin la = ce[5] - ce[4];     lb = ce[7] - ce[6];     lt = t_q[1]; end
      4'd9:  begin la = lerp_q[7];         lb = lerp_q[8];         lt = t_q[2]; end
      4'd10: begin la = ce[2] - ce[0];     lb = ce[3] - ce[1];     lt = t_q[0]; end
      4'd11: begin la = ce[6] - ce[4];     lb = ce[7] - ce[5];     lt = t_q[0]; end
      4'd12: begin la = lerp_q[10];        lb = lerp_q[11];        lt = t_q[2]; end
      4'd13: begin la = ce[4] - ce[0];     lb = ce[5] - ce[1];     lt = t_q[0]; end
      4'd14: begin la = ce[6] - ce[2];     lb = ce[7] - ce[3];     lt = t_q[0]; end
      default: begin la = lerp_q[13];      lb = lerp_q[14];        lt = t_q[1]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_en) begin
      lerp_q[cmd_i.sel] <= lerp(la, lb, lt);
    end
  end

  // round half away from zero, saturate to 48 bits
  assign r = 50'((prod_q + 66'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sat_q <= 1'b0;
    end else if (cmd_i.sfin) begin
      if (!g_sel[33]) begin
        if (r > GradMax) begin
          grad_q[cmd_i.sel[1:0]] <= GradMax[47:0];
          sat_q                  <= 1'b1;
        end else begin
          grad_q[cmd_i.sel[1:0]] <= r[47:0];
        end
      end else begin
        if (r > GradMin) begin
          grad_q[cmd_i.sel[1:0]] <= GradMin[47:0];
          sat_q                  <= 1'b1;
        end else begin
          grad_q[cmd_i.sel[1:0]] <= 48'(50'd0 - r);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (status_o.comp_ok) begin
        o_val_q <= lerp_q[6][31:0];
        o_gx_q  <= grad_q[0];
        o_gy_q  <= grad_q[1];
        o_gz_q  <= grad_q[2];
        o_sat_q <= sat_q;
      end else begin
        o_val_q <= '0;
        o_gx_q  <= '0;
        o_gy_q  <= '0;
        o_gz_q  <= '0;
        o_sat_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {o_gz_q, o_gy_q, o_gx_q, o_val_q};
  assign m_tuser_o  = o_sat_q;

  `TFIG_ASSERT(a_out_loaded, cmd_i.out_load |=> out_valid_q, "result register not set")
  `TFIG_ASSERT(a_no_wr_on_read, cmd_i.rd_en |-> !we, "memory port used twice")

endmodule

/* src/trilinear_field_interp_gradient_top.sv */
// Top level of the trilinear field interpolator with analytic gradient.
// Instantiates tfig_regs, tfig_ctrl and tfig_dp; depends on tfig_pkg.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata 152b request, tuser func
//  m_axis    out  tvalid/tready           tdata 176b result, tuser saturated
//  apb       in   psel/penable/pready     8 x 32b registers at 4*i
//
// A query with a valid component runs grid mapping on the shared multiplier,
// addressing, the eight corner reads through the single memory port, the lerp
// unit and gradient scaling, then output.
// The result register lets the next request in while a result waits for m_axis.
// Field memory is not cleared by reset; reset clears the sequencer and registers.
`timescale 1ns / 1ps

module trilinear_field_interp_gradient_top #(
  parameter int MAX_POINTS_X   = tfig_pkg::DefMaxPointsX,
  parameter int MAX_POINTS_Y   = tfig_pkg::DefMaxPointsY,
  parameter int MAX_POINTS_Z   = tfig_pkg::DefMaxPointsZ,
  parameter int NUM_COMPONENTS = tfig_pkg::DefNumComponents
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // component[2:0], sample_index[16:3], sample_value[48:17], pos_x[80:49],
  // pos_y[112:81], pos_z[144:113], zero pad
  input  logic [tfig_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [0:0]                    s_axis_tuser,   // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // field_value[31:0], grad_x[79:32], grad_y[127:80], grad_z[175:128]
  output logic [tfig_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,   // saturated
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tfig_pkg::cfg_t    cfg;
  tfig_pkg::cmd_t    cmd;
  tfig_pkg::status_t status;

  tfig_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfig_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfig_dp #(
    .MAX_POINTS_X   (MAX_POINTS_X),
    .MAX_POINTS_Y   (MAX_POINTS_Y),
    .MAX_POINTS_Z   (MAX_POINTS_Z),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser[0]),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser[0])
  );

endmodule
